[hdl/sq8_l2_distance_per_dimension_top_macros.svh]
// Assertion macros for the SQ8 L2 distance block
`ifndef SQ8_L2_DISTANCE_PER_DIMENSION_TOP_MACROS_SVH
`define SQ8_L2_DISTANCE_PER_DIMENSION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SQ8L2_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("%m: invariant violated");
`define SQ8L2_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("%m: sequence violated");
`else
`define SQ8L2_ASSERT(lbl, clk_s, rstn_s, prop)
`define SQ8L2_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

[hdl/sq8l2_pkg.sv]
// Shared types and constants of the SQ8 L2 distance block
package sq8l2_pkg;
	localparam int MAX_DIM_DEF = 1024;
	localparam int LANES_DEF   = 8;

	localparam int DIM_W    = 11;
	localparam int INDEX_W  = 10;
	localparam int VAL_W    = 16;
	localparam int CODE_W   = 8;
	localparam int CODES_W  = 64;
	localparam int CODE_LANES = CODES_W / CODE_W;
	localparam int DIST_W   = 61;
	localparam int VNUM_W   = 16;
	localparam int ACC_W    = 62;

	localparam int QM_W     = VAL_W + 1;
	localparam int SCPROD_W = CODE_W + VAL_W;
	localparam int DIFF_W   = SCPROD_W + 2;
	localparam int SQ_W     = 2 * DIFF_W - 2;
	localparam int LANE_LAT = 4;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(128);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_CODES = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] query_value;
		logic [VAL_W-1:0] min_value;
		logic [VAL_W-1:0] scale_value;
	} entry_t;

	typedef struct packed {
		logic adv;
		logic wr_en;
		logic use_lane;
	} lane_ctl_t;
endpackage

[hdl/sq8l2_if.sv]
// Handshake channels of the SQ8 L2 distance block
interface sq8l2_cmd_if import sq8l2_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [INDEX_W-1:0]   index;
	logic [VAL_W-1:0]     query_value;
	logic [VAL_W-1:0]     min_value;
	logic [VAL_W-1:0]     scale_value;
	logic [CODES_W-1:0]   codes;

	modport source (output valid, command, index, query_value, min_value, scale_value, codes,
		input ready);
	modport sink (input valid, command, index, query_value, min_value, scale_value, codes,
		output ready);
endinterface

interface sq8l2_res_if import sq8l2_pkg::*;;
	logic                valid;
	logic                ready;
	logic [DIST_W-1:0]   distance;
	logic [VNUM_W-1:0]   vector_number;

	modport source (output valid, distance, vector_number, input ready);
	modport sink (input valid, distance, vector_number, output ready);
endinterface

interface sq8l2_cfg_if import sq8l2_pkg::*;;
	logic               valid;
	logic               ready;
	logic [DIM_W-1:0]   dim;

	modport source (output valid, dim, input ready);
	modport sink (input valid, dim, output ready);
endinterface

[hdl/sq8l2_lane.sv]
// One lane: table bank, dequantisation and squared difference
module sq8l2_lane import sq8l2_pkg::*; #(
	parameter int ROWS = (MAX_DIM_DEF + LANES_DEF - 1) / LANES_DEF,
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic               clk,
	input  lane_ctl_t          ctl,
	input  logic [ROW_W-1:0]   wr_row,
	input  entry_t             wr_data,
	input  logic [ROW_W-1:0]   rd_row,
	input  logic [CODE_W-1:0]  code,
	output logic [SQ_W-1:0]    sq
);
	entry_t                     mem [ROWS];
	entry_t                     ent_s1;
	logic [CODE_W-1:0]          code_s1;
	logic                       use_s1, use_s2, use_s3;
	logic [SCPROD_W-1:0]        prod_s2;
	logic signed [QM_W-1:0]     qm_s2;
	logic signed [DIFF_W-1:0]   diff_s3;
	logic signed [2*DIFF_W-1:0] sq_full;
	logic [SQ_W-1:0]            sq_s4;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_row] <= wr_data;
		end
	end

	assign sq_full = diff_s3 * diff_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			ent_s1  <= mem[rd_row];
			code_s1 <= code;
			use_s1  <= ctl.use_lane;
			prod_s2 <= SCPROD_W'(code_s1) * SCPROD_W'(ent_s1.scale_value);
			qm_s2   <= QM_W'($signed(ent_s1.query_value)) - QM_W'($signed(ent_s1.min_value));
			use_s2  <= use_s1;
			diff_s3 <= DIFF_W'(qm_s2) - $signed(DIFF_W'(prod_s2));
			use_s3  <= use_s2;
			sq_s4   <= use_s3 ? sq_full[SQ_W-1:0] : '0;
		end
	end

	assign sq = sq_s4;
endmodule

[hdl/sq8l2_tree.sv]
// Registered adder tree merging the lane terms
module sq8l2_tree import sq8l2_pkg::*; #(
	parameter int LANES = LANES_DEF,
	localparam int TLV   = $clog2(LANES),
	localparam int SUM_W = SQ_W + TLV
) (
	input  logic              clk,
	input  logic              adv,
	input  logic [SQ_W-1:0]   sq [LANES],
	output logic [SUM_W-1:0]  sum
);
	localparam int LP = 1 << TLV;

	logic [SUM_W-1:0] leaf [LP];
	logic [SUM_W-1:0] node_q [TLV+1][LP];

	for (genvar n = 0; n < LP; n++) begin : g_leaf
		if (n < LANES) begin : g_used
			assign leaf[n] = SUM_W'(sq[n]);
		end else begin : g_pad
			assign leaf[n] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < LP; n++) begin
				node_q[0][n] <= leaf[n];
			end
			for (int l = 1; l <= TLV; l++) begin
				for (int n = 0; n < (LP >> l); n++) begin
					node_q[l][n] <= node_q[l-1][2*n] + node_q[l-1][2*n+1];
				end
			end
		end
	end

	assign sum = node_q[TLV][0];
endmodule

[hdl/sq8_l2_distance_per_dimension_top.sv]
// Squared L2 distance of SQ8 vectors to a stored query, top level
// Channels: cmd takes load items (command 0: one dimension's query, minimum
// and scale) and code items (command 1: LANES codes of the current
// vector, lowest byte first). result gives one distance and a wrapping
// vector number per vector once dim codes have arrived. cfg writes dim.
// Throughput: one item per cycle while result is not stalled; each code item
// is spread over LANES lanes, each reading its own table bank, so a chunk of
// LANES dimensions is taken as one item.
// Pipeline: after its last code item is taken, a result passes bank read,
// multiply, subtract, square, adder tree levels and the accumulator.
// Reset clears dim to 128, the position, accumulator and vector number;
// the tables hold nothing until loaded.
// When result is stalled the whole pipeline holds and cmd.ready drops;
// the waiting result sits in the output register.
`include "sq8_l2_distance_per_dimension_top_macros.svh"
module sq8_l2_distance_per_dimension_top import sq8l2_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int LANES   = LANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sq8l2_cmd_if.sink   cmd,
	sq8l2_res_if.source result,
	sq8l2_cfg_if.sink   cfg
);
	localparam int TLV      = $clog2(LANES);
	localparam int SUM_W    = SQ_W + TLV;
	localparam int ROWS     = (MAX_DIM + LANES - 1) / LANES;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LSEL_W   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CNT_W    = ($clog2(MAX_DIM + LANES) + 1 > DIM_W) ?
		$clog2(MAX_DIM + LANES) + 1 : DIM_W;
	localparam int DEPTH    = LANE_LAT + TLV + 1;
	localparam int RECIP_SH = INDEX_W + TLV;
	localparam int RECIP    = ((1 << RECIP_SH) + LANES - 1) / LANES;
	localparam int PROD_W   = RECIP_SH + INDEX_W + 2;

	logic [DIM_W-1:0]   dim_q;
	logic [CNT_W-1:0]   limit, pos_q;
	logic [ROW_W-1:0]   row_q, ld_row;
	logic [PROD_W-1:0]  ld_prod;
	logic [INDEX_W-1:0] ld_base;
	logic [LSEL_W-1:0]  ld_lane;
	logic               ld_ok, adv, accept, is_code, is_load, chunk_last;
	logic [LANES-1:0]   use_mask;
	logic [DEPTH:1]     vld_pipe_q, last_pipe_q;
	logic               fin_vld, fin_last;
	logic [SQ_W-1:0]    sq [LANES];
	logic [SUM_W-1:0]   sum;
	logic [ACC_W-1:0]   acc_q, acc_nxt;
	logic [ACC_W:0]     acc_sum;
	logic [DIST_W-1:0]  dist_nxt, dist_q;
	logic [VNUM_W-1:0]  vcnt_q, vnum_q;
	logic               out_vld_q;
	entry_t             wr_entry;
	lane_ctl_t          ctl [LANES];

	assign adv       = !out_vld_q || result.ready;
	assign cmd.ready = adv;
	assign cfg.ready = 1'b1;
	assign accept    = cmd.valid && adv;
	assign is_code   = accept && (cmd.command == CMD_CODES);
	assign is_load   = accept && (cmd.command == CMD_LOAD);

	always_comb begin
		if (dim_q == '0) begin
			limit = CNT_W'(1);
		end else if (CNT_W'(dim_q) > CNT_W'(MAX_DIM)) begin
			limit = CNT_W'(MAX_DIM);
		end else begin
			limit = CNT_W'(dim_q);
		end
	end

	assign chunk_last = (pos_q + CNT_W'(LANES)) >= limit;

	// bank = index mod LANES, row = index div LANES (reciprocal multiply)
	assign ld_prod  = PROD_W'(cmd.index) * PROD_W'(RECIP);
	assign ld_row   = ld_prod[RECIP_SH +: ROW_W];
	assign ld_base  = INDEX_W'(INDEX_W'(ld_row) * INDEX_W'(LANES));
	assign ld_lane  = LSEL_W'(cmd.index - ld_base);
	assign ld_ok    = 32'(cmd.index) < 32'(MAX_DIM);
	assign wr_entry = '{query_value: cmd.query_value, min_value: cmd.min_value,
		scale_value: cmd.scale_value};

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		logic [CODE_W-1:0] lane_code;

		if (k < CODE_LANES) begin : g_code
			assign lane_code = cmd.codes[k*CODE_W +: CODE_W];
		end else begin : g_nocode
			assign lane_code = '0;
		end

		assign use_mask[k]     = (pos_q + CNT_W'(k)) < limit;
		assign ctl[k].adv      = adv;
		assign ctl[k].wr_en    = is_load && ld_ok && (ld_lane == LSEL_W'(k));
		assign ctl[k].use_lane = use_mask[k];

		sq8l2_lane #(.ROWS(ROWS)) u_lane (
			.clk     (clk),
			.ctl     (ctl[k]),
			.wr_row  (ld_row),
			.wr_data (wr_entry),
			.rd_row  (row_q),
			.code    (lane_code),
			.sq      (sq[k])
		);
	end

	sq8l2_tree #(.LANES(LANES)) u_tree (
		.clk (clk),
		.adv (adv),
		.sq  (sq),
		.sum (sum)
	);

	assign fin_vld  = vld_pipe_q[DEPTH];
	assign fin_last = last_pipe_q[DEPTH];
	assign acc_sum  = {1'b0, acc_q} + (ACC_W+1)'(sum);
	assign acc_nxt  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign dist_nxt = (|acc_nxt[ACC_W-1:DIST_W]) ? '1 : acc_nxt[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q       <= DIM_RESET;
			pos_q       <= '0;
			row_q       <= '0;
			vld_pipe_q  <= '0;
			last_pipe_q <= '0;
			acc_q       <= '0;
			vcnt_q      <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				dim_q <= cfg.dim;
			end
			if (is_code) begin
				if (chunk_last) begin
					pos_q <= '0;
					row_q <= '0;
				end else begin
					pos_q <= pos_q + CNT_W'(LANES);
					row_q <= row_q + ROW_W'(1);
				end
			end
			if (adv) begin
				vld_pipe_q  <= {vld_pipe_q[DEPTH-1:1], is_code};
				last_pipe_q <= {last_pipe_q[DEPTH-1:1], chunk_last};
				out_vld_q   <= fin_vld && fin_last;
				if (fin_vld) begin
					if (fin_last) begin
						acc_q  <= '0;
						vcnt_q <= vcnt_q + VNUM_W'(1);
					end else begin
						acc_q <= acc_nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fin_vld && fin_last) begin
			dist_q <= dist_nxt;
			vnum_q <= vcnt_q;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.distance      = dist_q;
	assign result.vector_number = vnum_q;

	`SQ8L2_ASSERT(a_pos_row, clk, arst_n, pos_q == CNT_W'(CNT_W'(row_q) * CNT_W'(LANES)))
	`SQ8L2_ASSERT(a_use_prefix, clk, arst_n, (use_mask & (use_mask + LANES'(1))) == '0)
	`SQ8L2_ASSERT_NEXT(a_acc_clear, clk, arst_n, adv && fin_vld && fin_last, acc_q == '0 && out_vld_q)
endmodule

[sim/sq8_l2_distance_per_dimension_top_tb.sv]
// Self-checking testbench for the SQ8 squared L2 distance block
module sq8_l2_distance_per_dimension_top_tb;
	import sq8l2_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int TOTAL_ITEMS = 950;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [ACC_W-1:0] DIST_MAX = (ACC_W'(1) << DIST_W) - ACC_W'(1);

	typedef struct packed {
		logic               command;
		logic [INDEX_W-1:0] index;
		logic [VAL_W-1:0]   query_value;
		logic [VAL_W-1:0]   min_value;
		logic [VAL_W-1:0]   scale_value;
		logic [CODES_W-1:0] codes;
	} cmd_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [VNUM_W-1:0] vector_number;
	} vector_result_t;

	logic clk;
	logic arst_n;

	sq8l2_cmd_if cmd ();
	sq8l2_res_if result ();
	sq8l2_cfg_if cfg ();

	sq8_l2_distance_per_dimension_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result),
		.cfg    (cfg)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [VAL_W-1:0] query_tab [MAX_DIM_DEF];
	logic [VAL_W-1:0] min_tab [MAX_DIM_DEF];
	logic [VAL_W-1:0] scale_tab [MAX_DIM_DEF];
	logic [ACC_W-1:0] model_acc;
	int               model_pos;
	logic [VNUM_W-1:0] model_vnum;
	logic [DIM_W-1:0] model_dim;

	// stimulus generator state
	bit               written [MAX_DIM_DEF];
	int               gen_pos;
	int               gen_lim;

	cmd_item_t        cmd_backlog [$];
	vector_result_t   pending_distances [$];
	vector_result_t   want;
	cmd_item_t        outgoing;

	bit               cmd_fired;
	bit               res_fired;
	bit               no_idle;
	int               cmd_hold;
	int               res_hold;
	int               items_queued;
	int               items_taken;
	int               quiet_cycles;
	int               errors;

	function automatic int dims_in_use(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(v);
	endfunction

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic void predict_distance(input cmd_item_t it);
		int lim;
		int k;
		int d;
		longint rec;
		longint diff;
		logic [ACC_W-1:0] sq;
		logic [ACC_W:0] sum;
		vector_result_t res;
		if (it.command == CMD_LOAD) begin
			query_tab[it.index] = it.query_value;
			min_tab[it.index] = it.min_value;
			scale_tab[it.index] = it.scale_value;
			return;
		end
		lim = dims_in_use(model_dim);
		for (k = 0; k < LANES_DEF; k++) begin
			d = model_pos + k;
			if (d >= lim)
				break;
			rec = longint'($signed(min_tab[d]))
				+ longint'(it.codes[CODE_W*k +: CODE_W]) * longint'(scale_tab[d]);
			diff = longint'($signed(query_tab[d])) - rec;
			sq = ACC_W'(diff * diff);
			sum = {1'b0, model_acc} + {1'b0, sq};
			model_acc = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
		end
		model_pos += LANES_DEF;
		if (model_pos >= lim) begin
			res.distance = (model_acc > DIST_MAX) ? DIST_W'(DIST_MAX) : model_acc[DIST_W-1:0];
			res.vector_number = model_vnum;
			pending_distances.push_back(res);
			model_vnum = model_vnum + VNUM_W'(1);
			model_acc = '0;
			model_pos = 0;
		end
	endfunction

	function automatic logic [VAL_W-1:0] rand_val16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [CODES_W-1:0] rand_codes();
		logic [CODES_W-1:0] c;
		int k;
		case ($urandom_range(0, 7))
			0: c = '0;
			1: c = '1;
			2: begin
				for (k = 0; k < CODE_LANES; k++)
					c[CODE_W*k +: CODE_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: c = {$urandom, $urandom};
		endcase
		return c;
	endfunction

	function automatic void queue_load(input logic [INDEX_W-1:0] idx, input logic [VAL_W-1:0] q,
		input logic [VAL_W-1:0] m, input logic [VAL_W-1:0] s);
		cmd_item_t it;
		it.command = CMD_LOAD;
		it.index = idx;
		it.query_value = q;
		it.min_value = m;
		it.scale_value = s;
		it.codes = {$urandom, $urandom};
		written[idx] = 1'b1;
		cmd_backlog.push_back(it);
		items_queued++;
	endfunction

	// loads any entry the chunk reads that was never written; returns 1 when the vector ends
	function automatic bit queue_codes(input logic [CODES_W-1:0] codes);
		cmd_item_t it;
		int d;
		for (d = gen_pos; d < gen_pos + LANES_DEF && d < gen_lim; d++)
			if (!written[d])
				queue_load(INDEX_W'(d), rand_val16(), rand_val16(), rand_val16());
		it.command = CMD_CODES;
		it.index = INDEX_W'($urandom);
		it.query_value = VAL_W'($urandom);
		it.min_value = VAL_W'($urandom);
		it.scale_value = VAL_W'($urandom);
		it.codes = codes;
		cmd_backlog.push_back(it);
		items_queued++;
		gen_pos += LANES_DEF;
		if (gen_pos >= gen_lim) begin
			gen_pos = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void queue_vectors(input int count);
		int done;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 9) == 0)
				queue_load(INDEX_W'($urandom), rand_val16(), rand_val16(), rand_val16());
			if (queue_codes(rand_codes()))
				done++;
		end
	endfunction

	task automatic write_dim(input logic [DIM_W-1:0] value);
		@(negedge clk);
		cfg.dim <= value;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		model_dim = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
		gen_lim = dims_in_use(value);
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || pending_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// command driver
	always @(negedge clk) begin
		if (cmd_fired || !cmd.valid) begin
			if (cmd_hold != 0) begin
				cmd.valid <= 1'b0;
				cmd_hold = cmd_hold - 1;
			end else if (cmd_backlog.size() != 0) begin
				outgoing = cmd_backlog.pop_front();
				cmd.command <= outgoing.command;
				cmd.index <= outgoing.index;
				cmd.query_value <= outgoing.query_value;
				cmd.min_value <= outgoing.min_value;
				cmd.scale_value <= outgoing.scale_value;
				cmd.codes <= outgoing.codes;
				cmd.valid <= 1'b1;
				cmd_hold = draw_wait();
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (res_fired)
			res_hold = draw_wait();
		if (res_hold != 0) begin
			result.ready <= 1'b0;
			res_hold = res_hold - 1;
		end else begin
			result.ready <= 1'b1;
		end
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		cmd_fired = arst_n && cmd.valid && cmd.ready;
		res_fired = arst_n && result.valid && result.ready;
		if (cmd_fired) begin
			items_taken++;
			predict_distance({cmd.command, cmd.index, cmd.query_value, cmd.min_value,
				cmd.scale_value, cmd.codes});
		end
		if (res_fired) begin
			if (pending_distances.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got distance %0h vector %0d",
					$time, result.distance, result.vector_number);
			end else begin
				want = pending_distances.pop_front();
				if (result.distance !== want.distance) begin
					errors++;
					$display("%0t: distance expected %0h, got %0h", $time, want.distance,
						result.distance);
				end
				if (result.vector_number !== want.vector_number) begin
					errors++;
					$display("%0t: vector_number expected %0d, got %0d", $time,
						want.vector_number, result.vector_number);
				end
			end
		end
		if (cmd_fired || res_fired || (arst_n && cfg.valid && cfg.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int pick;
		int n;
		logic [DIM_W-1:0] new_dim;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.command = CMD_LOAD;
		cmd.index = '0;
		cmd.query_value = '0;
		cmd.min_value = '0;
		cmd.scale_value = '0;
		cmd.codes = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.dim = '0;
		for (int i = 0; i < MAX_DIM_DEF; i++) begin
			query_tab[i] = '0;
			min_tab[i] = '0;
			scale_tab[i] = '0;
			written[i] = 1'b0;
		end
		model_acc = '0;
		model_pos = 0;
		model_vnum = '0;
		model_dim = DIM_RESET;
		gen_pos = 0;
		gen_lim = dims_in_use(DIM_RESET);
		no_idle = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of dim
		queue_vectors(2);
		wait_idle();

		// extreme terms on a single dimension
		write_dim(DIM_W'(1));
		queue_load(INDEX_W'(0), 16'h7FFF, 16'h8000, 16'hFFFF);
		void'(queue_codes('1));
		void'(queue_codes('0));
		queue_load(INDEX_W'(0), 16'h8000, 16'h7FFF, 16'hFFFF);
		void'(queue_codes('1));
		queue_load(INDEX_W'(0), 16'h0000, 16'h0000, 16'h0000);
		void'(queue_codes(rand_codes()));
		wait_idle();

		// dim zero behaves as one
		write_dim(DIM_W'(0));
		queue_vectors(2);
		wait_idle();

		// partial last chunk
		write_dim(DIM_W'(13));
		no_idle = 1'b1;
		queue_vectors(2);
		wait_idle();
		no_idle = 1'b0;

		// dim lowered below the position reached
		write_dim(DIM_W'(40));
		repeat (3) void'(queue_codes(rand_codes()));
		wait_idle();
		write_dim(DIM_W'(16));
		queue_vectors(2);
		wait_idle();

		while (items_queued < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				new_dim = '0;
			else if (pick == 1)
				new_dim = DIM_W'(1);
			else if (pick < 9)
				new_dim = DIM_W'($urandom_range(41, 300));
			else
				new_dim = DIM_W'($urandom_range(2, 40));
			no_idle = ($urandom_range(0, 3) == 0);
			write_dim(new_dim);
			queue_vectors(dims_in_use(new_dim) > 64 ? 1 : $urandom_range(1, 5));
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 4);
				while (n > 0 && gen_pos + LANES_DEF < gen_lim) begin
					void'(queue_codes(rand_codes()));
					n--;
				end
			end
			wait_idle();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
